[src/lcpb_pkg.sv]
package lcpb_pkg;

    // fixed port widths of the item fields
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PORT_LED = 3;

    // blink period storage and limits
    localparam int unsigned PERIOD_W = 14;
    typedef logic [PERIOD_W-1:0] period_t;

    localparam period_t PERIOD_MIN   = 14'd50;
    localparam period_t PERIOD_MAX   = 14'd15000;
    localparam period_t PERIOD_SAT   = 14'd15001;
    localparam period_t PERIOD_RST_0 = 14'd50;
    localparam period_t PERIOD_RST_1 = 14'd100;
    localparam period_t PERIOD_RST_2 = 14'd75;

    // accumulator of the decimal scan, holds PERIOD_SAT * 10 + 9
    localparam int unsigned ACC_W = 18;
    typedef logic [ACC_W-1:0] acc_t;

    typedef logic [BYTE_W-1:0] char_t;

    localparam char_t CHAR_RESTART = 8'h24;  // '$'
    localparam char_t CHAR_END     = 8'h26;  // '&'
    localparam char_t CHAR_L       = 8'h4C;  // 'L'
    localparam char_t CHAR_O       = 8'h4F;  // 'O'
    localparam char_t CHAR_N       = 8'h4E;  // 'N'
    localparam char_t CHAR_F       = 8'h46;  // 'F'
    localparam char_t CHAR_ZERO    = 8'h30;  // '0'
    localparam char_t CHAR_ONE     = 8'h31;  // '1'
    localparam char_t CHAR_NINE    = 8'h39;  // '9'
    localparam char_t CHAR_NUL     = 8'h00;

endpackage

[src/led_command_parser_blinker.sv]
// channel | signals                                         | direction
// --------+-------------------------------------------------+----------
// input   | in_valid, in_ready, byte_valid, rx_byte,        | into block
//         | button_levels, now_ms                           |
// output  | out_valid, out_ready, led_levels, blink_enables | out of block
//
// one input transfer gives exactly one output transfer
// the scan and the blink pass each reuse one compare unit, one step a cycle
// rst_n clears all state asynchronously; the buffer is flops, so no sweep
// in_ready is low while an item is worked on; a finished result waits in the
// output register and only the final step stalls on a held result

module led_command_parser_blinker #(
    parameter int unsigned BUFFER_BYTES = 11,
    parameter int unsigned LED_COUNT    = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              byte_valid,
    input  logic [lcpb_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [lcpb_pkg::PORT_LED-1:0]     button_levels,
    input  logic [lcpb_pkg::TIME_W-1:0]       now_ms,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lcpb_pkg::PORT_LED-1:0]     led_levels,
    output logic [lcpb_pkg::PORT_LED-1:0]     blink_enables
);

    // write pointer indexes the buffer; scan index also holds BUFFER_BYTES
    localparam int unsigned WP_W  = $clog2(BUFFER_BYTES);
    localparam int unsigned IX_W  = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int unsigned PL    = lcpb_pkg::PORT_LED;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE,
        ST_CMD,
        ST_SCAN,
        ST_BUTTON,
        ST_BLINK,
        ST_DONE
    } state_t;

    state_t                          state_reg;

    // captured item
    logic                            byte_valid_reg;
    lcpb_pkg::char_t                 rx_byte_reg;
    logic [PL-1:0]                   buttons_reg;
    logic [lcpb_pkg::TIME_W-1:0]     now_reg;

    // command state
    lcpb_pkg::char_t                 buf_reg [BUFFER_BYTES];
    logic [WP_W-1:0]                 wp_reg;
    logic [IX_W-1:0]                 scan_idx_reg;
    lcpb_pkg::acc_t                  value_reg;
    logic [LED_W-1:0]                led_sel_reg;

    // per-led state
    lcpb_pkg::period_t               period_reg [LED_COUNT];
    logic [lcpb_pkg::TIME_W-1:0]     last_reg   [LED_COUNT];
    logic [LED_COUNT-1:0]            enable_reg;
    logic [LED_COUNT-1:0]            press_reg;
    logic [LED_COUNT-1:0]            release_reg;
    logic [LED_COUNT-1:0]            pin_reg;
    logic [LED_W-1:0]                blink_idx_reg;

    // output register
    logic                            out_valid_reg;
    logic [PL-1:0]                   led_out_reg;
    logic [PL-1:0]                   en_out_reg;

    // combinational helpers
    logic [WP_W:0]                   wp_inc;
    logic [WP_W-1:0]                 wp_next;
    lcpb_pkg::char_t                 scan_char;
    logic                            scan_end;
    logic                            scan_digit;
    lcpb_pkg::acc_t                  value_mul;
    lcpb_pkg::acc_t                  value_next;
    logic                            digit_ok;
    logic [LED_W-1:0]                led_from_digit;
    lcpb_pkg::char_t                 digit_diff;
    logic [lcpb_pkg::TIME_W-1:0]     elapsed;
    logic                            blink_due;
    logic [LED_COUNT+PL-1:0]         levels_pad;
    logic [LED_COUNT-1:0]            levels;
    logic [LED_COUNT+PL-1:0]         pin_pad;
    logic [LED_COUNT+PL-1:0]         en_pad;
    logic [LED_COUNT-1:0]            pin_btn;
    logic [LED_COUNT-1:0]            en_btn;
    logic [LED_COUNT-1:0]            press_btn;
    logic [LED_COUNT-1:0]            release_btn;
    logic                            periods_ok;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign led_levels    = led_out_reg;
    assign blink_enables = en_out_reg;

    // write pointer advance with wrap
    assign wp_inc  = {1'b0, wp_reg} + {{WP_W{1'b0}}, 1'b1};
    assign wp_next = (wp_inc == (WP_W+1)'(BUFFER_BYTES)) ? '0 : wp_inc[WP_W-1:0];

    // led digit of the command, '1' .. '0' + LED_COUNT
    assign digit_diff     = buf_reg[1] - lcpb_pkg::CHAR_ONE;
    assign digit_ok       = (buf_reg[1] >= lcpb_pkg::CHAR_ONE) &&
                            (buf_reg[1] <= lcpb_pkg::BYTE_W'(48 + LED_COUNT));
    assign led_from_digit = digit_diff[LED_W-1:0];

    // decimal scan step: value * 10 + digit, saturated above the limit
    always_comb
    begin
        scan_char  = (scan_idx_reg < IX_W'(BUFFER_BYTES)) ?
                     buf_reg[scan_idx_reg[WP_W-1:0]] : lcpb_pkg::CHAR_NUL;
        scan_end   = (scan_idx_reg >= IX_W'(BUFFER_BYTES)) ||
                     (scan_char == lcpb_pkg::CHAR_NUL);
        scan_digit = (scan_char >= lcpb_pkg::CHAR_ZERO) &&
                     (scan_char <= lcpb_pkg::CHAR_NINE);
        value_mul  = (value_reg << 3) + (value_reg << 1) +
                     lcpb_pkg::ACC_W'(scan_char - lcpb_pkg::CHAR_ZERO);
        value_next = (value_mul > lcpb_pkg::ACC_W'(lcpb_pkg::PERIOD_MAX)) ?
                     lcpb_pkg::ACC_W'(lcpb_pkg::PERIOD_SAT) : value_mul;
    end

    // shared blink compare, one led per cycle
    assign elapsed   = now_reg - last_reg[blink_idx_reg];
    assign blink_due = enable_reg[blink_idx_reg] &&
                       (elapsed >= lcpb_pkg::TIME_W'(period_reg[blink_idx_reg]));

    // buttons beyond the port read as low
    assign levels_pad = {{LED_COUNT{1'b0}}, buttons_reg};
    assign levels     = levels_pad[LED_COUNT-1:0];

    // button edge logic, all leds are independent
    always_comb
    begin
        pin_btn     = pin_reg;
        en_btn      = enable_reg;
        press_btn   = press_reg;
        release_btn = release_reg;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if (!levels[i] && !press_reg[i])
            begin
                press_btn[i]   = 1'b1;
                release_btn[i] = 1'b0;
            end
            if (levels[i] && !release_reg[i])
            begin
                press_btn[i]   = 1'b0;
                release_btn[i] = 1'b1;
                en_btn[i]      = ~enable_reg[i];
                pin_btn[i]     = ~enable_reg[i];
            end
        end
    end

    assign pin_pad = {{PL{1'b0}}, pin_reg};
    assign en_pad  = {{PL{1'b0}}, enable_reg};

    always_comb
    begin
        periods_ok = 1'b1;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if ((period_reg[i] < lcpb_pkg::PERIOD_MIN) ||
                (period_reg[i] > lcpb_pkg::PERIOD_MAX))
            begin
                periods_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_valid_reg <= 1'b0;
            rx_byte_reg    <= '0;
            buttons_reg    <= '0;
            now_reg        <= '0;
            for (int i = 0; i < BUFFER_BYTES; i++)
            begin
                buf_reg[i] <= lcpb_pkg::CHAR_NUL;
            end
            wp_reg         <= '0;
            scan_idx_reg   <= '0;
            value_reg      <= '0;
            led_sel_reg    <= '0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                period_reg[i] <= (i == 1) ? lcpb_pkg::PERIOD_RST_1 :
                                 (i == 2) ? lcpb_pkg::PERIOD_RST_2 :
                                            lcpb_pkg::PERIOD_RST_0;
                last_reg[i]   <= '0;
            end
            enable_reg     <= '0;
            press_reg      <= '0;
            release_reg    <= '0;
            pin_reg        <= '0;
            blink_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
            led_out_reg    <= '0;
            en_out_reg     <= '0;
        end
        else
        begin
            // result leaves on its transfer, unless the done step reloads it
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        byte_valid_reg <= byte_valid;
                        rx_byte_reg    <= rx_byte;
                        buttons_reg    <= button_levels;
                        now_reg        <= now_ms;
                        state_reg      <= ST_BYTE;
                    end
                end

                ST_BYTE:
                begin
                    if (byte_valid_reg && (rx_byte_reg == lcpb_pkg::CHAR_END))
                    begin
                        // terminate the text, then decode next cycle
                        buf_reg[wp_reg] <= lcpb_pkg::CHAR_NUL;
                        state_reg       <= ST_CMD;
                    end
                    else
                    begin
                        state_reg <= ST_BUTTON;
                        if (byte_valid_reg)
                        begin
                            if (rx_byte_reg == lcpb_pkg::CHAR_RESTART)
                            begin
                                wp_reg <= '0;
                            end
                            else
                            begin
                                buf_reg[wp_reg] <= rx_byte_reg;
                                wp_reg          <= wp_next;
                            end
                        end
                    end
                end

                ST_CMD:
                begin
                    if (buf_reg[0] != lcpb_pkg::CHAR_L)
                    begin
                        for (int i = 0; i < BUFFER_BYTES; i++)
                        begin
                            buf_reg[i] <= lcpb_pkg::CHAR_NUL;
                        end
                        wp_reg    <= '0;
                        state_reg <= ST_BUTTON;
                    end
                    else if (digit_ok)
                    begin
                        led_sel_reg <= led_from_digit;
                        if (buf_reg[2] == lcpb_pkg::CHAR_O)
                        begin
                            if (buf_reg[3] == lcpb_pkg::CHAR_N)
                            begin
                                pin_reg[led_from_digit] <= 1'b1;
                            end
                            else if ((buf_reg[3] == lcpb_pkg::CHAR_F) &&
                                     (buf_reg[4] == lcpb_pkg::CHAR_F))
                            begin
                                pin_reg[led_from_digit] <= 1'b0;
                            end
                            for (int i = 0; i < BUFFER_BYTES; i++)
                            begin
                                buf_reg[i] <= lcpb_pkg::CHAR_NUL;
                            end
                            wp_reg    <= '0;
                            state_reg <= ST_BUTTON;
                        end
                        else
                        begin
                            // period digits start after the led digit
                            scan_idx_reg <= IX_W'(2);
                            value_reg    <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                    else
                    begin
                        // a bad led digit keeps buffer and pointer
                        state_reg <= ST_BUTTON;
                    end
                end

                ST_SCAN:
                begin
                    if (scan_end || !scan_digit)
                    begin
                        if (scan_end &&
                            (value_reg >= lcpb_pkg::ACC_W'(lcpb_pkg::PERIOD_MIN)) &&
                            (value_reg <= lcpb_pkg::ACC_W'(lcpb_pkg::PERIOD_MAX)))
                        begin
                            period_reg[led_sel_reg] <= value_reg[lcpb_pkg::PERIOD_W-1:0];
                        end
                        for (int i = 0; i < BUFFER_BYTES; i++)
                        begin
                            buf_reg[i] <= lcpb_pkg::CHAR_NUL;
                        end
                        wp_reg    <= '0;
                        state_reg <= ST_BUTTON;
                    end
                    else
                    begin
                        value_reg    <= value_next;
                        scan_idx_reg <= scan_idx_reg + IX_W'(1);
                    end
                end

                ST_BUTTON:
                begin
                    pin_reg       <= pin_btn;
                    enable_reg    <= en_btn;
                    press_reg     <= press_btn;
                    release_reg   <= release_btn;
                    blink_idx_reg <= '0;
                    state_reg     <= ST_BLINK;
                end

                ST_BLINK:
                begin
                    if (blink_due)
                    begin
                        last_reg[blink_idx_reg] <= now_reg;
                        pin_reg[blink_idx_reg]  <= ~pin_reg[blink_idx_reg];
                    end
                    if (blink_idx_reg == LED_W'(LED_COUNT - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        blink_idx_reg <= blink_idx_reg + LED_W'(1);
                    end
                end

                ST_DONE:
                begin
                    // wait only while an older result is still held
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        led_out_reg   <= pin_pad[PL-1:0];
                        en_out_reg    <= en_pad[PL-1:0];
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // pointer stays inside the buffer
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wp_reg} < (WP_W+1)'(BUFFER_BYTES)))
        else $error("write pointer outside buffer");

    // an accepted item closes the input until its work is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input open right after a transfer");

    // stored periods never leave the legal window
    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        periods_ok)
        else $error("blink period out of range");

    // the scan never runs past the end of the buffer
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= IX_W'(BUFFER_BYTES)))
        else $error("scan index past buffer end");

    // a finished item only leaves the done step by loading the output register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("result not loaded");

endmodule
